[design/qrs_pkg.sv]
// ============================================================================
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ============================================================================
package qrs_pkg;

    // Fraction bits of the result words.
    localparam int FRAC_BITS_OUT = 16;

    localparam int COEF_W = 16;                 // coefficient width
    localparam int DISC_W = 35;                 // signed discriminant width
    localparam int DMAG_W = 34;                 // discriminant magnitude width
    localparam int SQ_W   = 17 + FRAC_BITS_OUT; // square root width
    localparam int NUM_W  = SQ_W;               // dividend and quotient width
    localparam int DEN_W  = 17;                 // divisor magnitude width
    localparam int RES_W  = 32;                 // result word width
    localparam int EXT_W  = (NUM_W + 2 > RES_W + 1) ? NUM_W + 2 : RES_W + 1;

    typedef enum logic [2:0] {
        CASE_REAL     = 3'd0,
        CASE_COMPLEX  = 3'd1,
        CASE_LINEAR   = 3'd2,
        CASE_NONE     = 3'd3,
        CASE_INFINITE = 3'd4
    } t_case_kind;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_coef;

    typedef struct packed {
        t_case_kind              case_kind;
        logic signed [RES_W-1:0] first_root_real;
        logic signed [RES_W-1:0] second_root_real;
        logic signed [RES_W-1:0] imag_part;
        logic                    saturated;
    } t_result;

    // Everything the front end hands on besides the discriminant.
    typedef struct packed {
        t_case_kind         kind;
        logic [NUM_W-1:0]   n1_mag;
        logic [DEN_W-1:0]   d1_mag;
        logic [DEN_W-1:0]   d2_mag;
        logic               q1_neg;
        logic               q2_neg;
    } t_side;

    // Control that rides alongside the dividers.
    typedef struct packed {
        t_case_kind kind;
        logic       q1_neg;
        logic       q2_neg;
    } t_tail;

endpackage

[design/qrs_front.sv]
// ============================================================================
// qrs_front
// Two stages: coefficient products, then discriminant and divider setup.
// ============================================================================
module qrs_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  qrs_pkg::t_coef             i_coef,
    output logic                       o_valid,
    output logic [qrs_pkg::DMAG_W-1:0] o_dmag,
    output qrs_pkg::t_side             o_side
);

    logic                              r_v1;
    qrs_pkg::t_coef                    r_coef;
    logic signed [31:0]                r_bb;
    logic signed [31:0]                r_ac;

    logic                              r_v2;
    logic [qrs_pkg::DMAG_W-1:0]        r_dmag;
    qrs_pkg::t_side                    r_side;

    logic signed [qrs_pkg::DISC_W-1:0] disc;
    logic signed [qrs_pkg::DISC_W-1:0] disc_abs;
    logic [qrs_pkg::COEF_W-1:0]        abs_a;
    logic [qrs_pkg::COEF_W-1:0]        abs_b;
    logic [qrs_pkg::COEF_W-1:0]        abs_c;
    logic [qrs_pkg::DMAG_W-1:0]        n_dmag;
    qrs_pkg::t_side                    n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= i_coef;
        r_bb   <= i_coef.coef_b * i_coef.coef_b;
        r_ac   <= i_coef.coef_a * i_coef.coef_c;
        r_dmag <= n_dmag;
        r_side <= n_side;
    end

    always_comb begin
        disc     = qrs_pkg::DISC_W'(r_bb) - (qrs_pkg::DISC_W'(r_ac) <<< 2);
        disc_abs = disc[qrs_pkg::DISC_W-1] ? -disc : disc;
        n_dmag   = disc_abs[qrs_pkg::DMAG_W-1:0];
        abs_a    = r_coef.coef_a[qrs_pkg::COEF_W-1] ? qrs_pkg::COEF_W'(-r_coef.coef_a)
                                                    : r_coef.coef_a;
        abs_b    = r_coef.coef_b[qrs_pkg::COEF_W-1] ? qrs_pkg::COEF_W'(-r_coef.coef_b)
                                                    : r_coef.coef_b;
        abs_c    = r_coef.coef_c[qrs_pkg::COEF_W-1] ? qrs_pkg::COEF_W'(-r_coef.coef_c)
                                                    : r_coef.coef_c;
        n_side.d2_mag = {abs_a, 1'b0};
        n_side.q2_neg = r_coef.coef_a[qrs_pkg::COEF_W-1];
        if (r_coef.coef_a != '0) begin
            // Real part: -B / (2A).
            n_side.kind   = disc[qrs_pkg::DISC_W-1] ? qrs_pkg::CASE_COMPLEX
                                                    : qrs_pkg::CASE_REAL;
            n_side.n1_mag = qrs_pkg::NUM_W'(abs_b) << qrs_pkg::FRAC_BITS_OUT;
            n_side.d1_mag = {abs_a, 1'b0};
            n_side.q1_neg = (r_coef.coef_b > 0) ^ r_coef.coef_a[qrs_pkg::COEF_W-1];
        end else begin
            // Linear root: -C / B.
            if (r_coef.coef_b != '0) begin
                n_side.kind = qrs_pkg::CASE_LINEAR;
            end else if (r_coef.coef_c != '0) begin
                n_side.kind = qrs_pkg::CASE_NONE;
            end else begin
                n_side.kind = qrs_pkg::CASE_INFINITE;
            end
            n_side.n1_mag = qrs_pkg::NUM_W'(abs_c) << qrs_pkg::FRAC_BITS_OUT;
            n_side.d1_mag = {1'b0, abs_b};
            n_side.q1_neg = (r_coef.coef_c > 0) ^ r_coef.coef_b[qrs_pkg::COEF_W-1];
        end
    end

    assign o_valid = r_v2;
    assign o_dmag  = r_dmag;
    assign o_side  = r_side;

endmodule

[design/qrs_sqrt.sv]
// ============================================================================
// qrs_sqrt
// Pipelined restoring square root, one root bit per stage.
// ============================================================================
module qrs_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [qrs_pkg::DMAG_W-1:0] i_dmag,
    output logic                       o_valid,
    output logic [qrs_pkg::SQ_W-1:0]   o_root
);

    localparam int OP_W  = 2 * qrs_pkg::SQ_W;
    localparam int REM_W = qrs_pkg::SQ_W + 2;
    localparam int NST   = qrs_pkg::SQ_W;

    logic                     r_v    [NST];
    logic [OP_W-1:0]          r_op   [NST];
    logic [qrs_pkg::SQ_W-1:0] r_root [NST];
    logic [REM_W-1:0]         r_rem  [NST];

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic                     v_i;
        logic [OP_W-1:0]          op_i;
        logic [qrs_pkg::SQ_W-1:0] root_i;
        logic [REM_W-1:0]         rem_i;
        logic [REM_W-1:0]         rem_sh;
        logic [REM_W-1:0]         trial;
        logic                     ge;
        logic [REM_W-1:0]         n_rem;

        if (s == 0) begin : g_first
            // The operand is the discriminant magnitude scaled by 2^(2F).
            assign v_i    = i_valid;
            assign op_i   = {i_dmag, {(2 * qrs_pkg::FRAC_BITS_OUT){1'b0}}};
            assign root_i = '0;
            assign rem_i  = '0;
        end else begin : g_next
            assign v_i    = r_v[s-1];
            assign op_i   = r_op[s-1];
            assign root_i = r_root[s-1];
            assign rem_i  = r_rem[s-1];
        end

        always_comb begin
            rem_sh = {rem_i[REM_W-3:0], op_i[OP_W-1:OP_W-2]};
            trial  = {root_i, 2'b01};
            ge     = rem_sh >= trial;
            n_rem  = ge ? rem_sh - trial : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            r_op[s]   <= op_i << 2;
            r_root[s] <= {root_i[qrs_pkg::SQ_W-2:0], ge};
            r_rem[s]  <= n_rem;
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_root  = r_root[NST-1];

endmodule

[design/qrs_div.sv]
// ============================================================================
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ============================================================================
module qrs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [qrs_pkg::NUM_W-1:0] i_num,
    input  logic [qrs_pkg::DEN_W-1:0] i_den,
    output logic                      o_valid,
    output logic [qrs_pkg::NUM_W-1:0] o_quot
);

    localparam int REM_W = qrs_pkg::DEN_W + 1;
    localparam int NST   = qrs_pkg::NUM_W;

    logic                      r_v   [NST];
    logic [qrs_pkg::NUM_W-1:0] r_qn  [NST];
    logic [qrs_pkg::DEN_W-1:0] r_den [NST];
    logic [REM_W-1:0]          r_rem [NST];

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic                      v_i;
        logic [qrs_pkg::NUM_W-1:0] qn_i;
        logic [qrs_pkg::DEN_W-1:0] den_i;
        logic [REM_W-1:0]          rem_i;
        logic [REM_W-1:0]          rem_sh;
        logic                      ge;
        logic [REM_W-1:0]          n_rem;

        if (s == 0) begin : g_first
            assign v_i   = i_valid;
            assign qn_i  = i_num;
            assign den_i = i_den;
            assign rem_i = '0;
        end else begin : g_next
            assign v_i   = r_v[s-1];
            assign qn_i  = r_qn[s-1];
            assign den_i = r_den[s-1];
            assign rem_i = r_rem[s-1];
        end

        // Dividend bits shift out at the top while quotient bits fill in below.
        always_comb begin
            rem_sh = {rem_i[REM_W-2:0], qn_i[qrs_pkg::NUM_W-1]};
            ge     = rem_sh >= {1'b0, den_i};
            n_rem  = ge ? rem_sh - {1'b0, den_i} : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            r_qn[s]  <= {qn_i[qrs_pkg::NUM_W-2:0], ge};
            r_den[s] <= den_i;
            r_rem[s] <= n_rem;
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_quot  = r_qn[NST-1];

endmodule

[design/qrs_back.sv]
// ============================================================================
// qrs_back
// Applies signs, forms the roots, saturates and registers the result.
// ============================================================================
module qrs_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  qrs_pkg::t_tail            i_tail,
    input  logic [qrs_pkg::NUM_W-1:0] i_q1,
    input  logic [qrs_pkg::NUM_W-1:0] i_q2,
    output logic                      o_done,
    output qrs_pkg::t_result          o_result
);

    localparam int EW = qrs_pkg::EXT_W;
    localparam logic signed [EW-1:0] MAX_V =
        {{(EW - qrs_pkg::RES_W + 1){1'b0}}, {(qrs_pkg::RES_W - 1){1'b1}}};
    localparam logic signed [EW-1:0] MIN_V =
        {{(EW - qrs_pkg::RES_W + 1){1'b1}}, {(qrs_pkg::RES_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [qrs_pkg::RES_W-1:0] val;
        logic                             sat;
    } t_clip;

    function automatic t_clip clip(input logic signed [EW-1:0] v);
        t_clip r;
        if (v > MAX_V) begin
            r.val = MAX_V[qrs_pkg::RES_W-1:0];
            r.sat = 1'b1;
        end else if (v < MIN_V) begin
            r.val = MIN_V[qrs_pkg::RES_W-1:0];
            r.sat = 1'b1;
        end else begin
            r.val = v[qrs_pkg::RES_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    logic                signed [EW-1:0] f;
    logic                signed [EW-1:0] g;
    t_clip               c_lo;
    t_clip               c_hi;
    t_clip               c_f;
    t_clip               c_g;
    qrs_pkg::t_result    n_result;
    logic                r_done;
    qrs_pkg::t_result    r_result;

    always_comb begin
        f    = i_tail.q1_neg ? -$signed(EW'(i_q1)) : $signed(EW'(i_q1));
        g    = i_tail.q2_neg ? -$signed(EW'(i_q2)) : $signed(EW'(i_q2));
        c_lo = clip(f - g);
        c_hi = clip(f + g);
        c_f  = clip(f);
        c_g  = clip(g);
        n_result                  = '0;
        n_result.case_kind        = i_tail.kind;
        case (i_tail.kind)
            qrs_pkg::CASE_REAL: begin
                n_result.first_root_real  = c_lo.val;
                n_result.second_root_real = c_hi.val;
                n_result.saturated        = c_lo.sat | c_hi.sat;
            end
            qrs_pkg::CASE_COMPLEX: begin
                n_result.first_root_real  = c_f.val;
                n_result.second_root_real = c_f.val;
                n_result.imag_part        = c_g.val;
                n_result.saturated        = c_f.sat | c_g.sat;
            end
            qrs_pkg::CASE_LINEAR: begin
                n_result.first_root_real  = c_f.val;
                n_result.saturated        = c_f.sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[design/quadratic_root_solver_top.sv]
// ============================================================================
// quadratic_root_solver_top
// Fixed-point solver for a*x^2 + b*x + c = 0 with Q8.8 in, Q16.16 out.
// ============================================================================
// Usage: drive the three coefficients on i_coef and raise start for one cycle
// per word. A word is taken at each rising edge where start is high and busy
// is low. busy is only high while reset is held, so one word can be issued
// every clock cycle.
// Each word yields exactly one result word on o_result, shown for one cycle
// with o_done high. The throughput is one word per cycle. Each word passes
// through a chain of units: two front stages form the products and the
// discriminant, the square root resolves one root bit per stage, two
// parallel dividers resolve one quotient bit per stage, and one output
// stage applies signs and saturation.
// Results come back in issue order. The receiver has no way to stall the
// pipeline, so it must capture each result in the cycle o_done is high.
// Synchronous reset clears every valid bit, so words in flight are dropped
// and no result appears until new words are issued.
// ============================================================================
module quadratic_root_solver_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  qrs_pkg::t_coef   i_coef,
    output logic             o_done,
    output qrs_pkg::t_result o_result
);

    logic                       front_valid;
    logic [qrs_pkg::DMAG_W-1:0] front_dmag;
    qrs_pkg::t_side             front_side;

    logic                       sqrt_valid;
    logic [qrs_pkg::SQ_W-1:0]   sqrt_root;

    // Side data waits alongside the square root and then alongside the
    // dividers, so it lines up with the values it belongs to.
    qrs_pkg::t_side             r_side [qrs_pkg::SQ_W];
    qrs_pkg::t_tail             r_tail [qrs_pkg::NUM_W];
    qrs_pkg::t_side             side_out;
    qrs_pkg::t_tail             n_tail;

    logic                       div1_valid;
    logic                       div2_valid;
    logic [qrs_pkg::NUM_W-1:0]  div1_quot;
    logic [qrs_pkg::NUM_W-1:0]  div2_quot;

    // The pipeline never stalls, so the only time a word is refused is reset.
    assign busy = ~i_rst_n;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_coef  (i_coef),
        .o_valid (front_valid),
        .o_dmag  (front_dmag),
        .o_side  (front_side)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_dmag  (front_dmag),
        .o_valid (sqrt_valid),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        r_side[0] <= front_side;
        for (int i = 1; i < qrs_pkg::SQ_W; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    assign side_out = r_side[qrs_pkg::SQ_W-1];

    // The first divider gives the real part (or the linear root), the second
    // gives the root offset or the imaginary part.
    qrs_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sqrt_valid),
        .i_num   (side_out.n1_mag),
        .i_den   (side_out.d1_mag),
        .o_valid (div1_valid),
        .o_quot  (div1_quot)
    );

    qrs_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sqrt_valid),
        .i_num   (sqrt_root),
        .i_den   (side_out.d2_mag),
        .o_valid (div2_valid),
        .o_quot  (div2_quot)
    );

    always_comb begin
        n_tail.kind   = side_out.kind;
        n_tail.q1_neg = side_out.q1_neg;
        n_tail.q2_neg = side_out.q2_neg;
    end

    always_ff @(posedge i_clk) begin
        r_tail[0] <= n_tail;
        for (int i = 1; i < qrs_pkg::NUM_W; i++) begin
            r_tail[i] <= r_tail[i-1];
        end
    end

    qrs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div1_valid & div2_valid),
        .i_tail   (r_tail[qrs_pkg::NUM_W-1]),
        .i_q1     (div1_quot),
        .i_q2     (div2_quot),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
